[hdl/art_pkg.sv]
`default_nettype none

package art_pkg;

    localparam int ADDR_W      = 64;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_PAD_W   = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOOKUP = 2'd3
    } art_op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_OVERLAP   = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } art_status_t;

    // Key broadcast to every cell of the chain.
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] key_end;
    } art_cmd_t;

    // Contents of one cell.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } art_entry_t;

    // Registered compare results of one cell.
    typedef struct packed {
        logic valid;
        logic below;          // valid and start below key
        logic le;             // valid and start at or below key
        logic key_lt_end;     // key below the stored end
        logic key_le_end;     // key at or below the stored end
        logic start_lt_kend;  // stored start below the new end
    } art_flag_t;

    // Update command from the sequencer to all cells.
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } art_ctl_t;

endpackage

`default_nettype wire

[hdl/art_cell.sv]
`default_nettype none

module art_cell (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire art_pkg::art_cmd_t    cmd,
    input  wire art_pkg::art_ctl_t    ctl,
    input  wire logic                 left_below,
    input  wire art_pkg::art_entry_t  left_entry,
    input  wire art_pkg::art_entry_t  right_entry,
    output art_pkg::art_entry_t       entry,
    output art_pkg::art_flag_t        flag
);
    import art_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ADDR_W-1:0]    start_reg;
    logic [ADDR_W-1:0]    start_next;
    logic [ADDR_W-1:0]    end_reg;
    logic [ADDR_W-1:0]    end_next;
    art_flag_t            flag_reg;
    art_flag_t            flag_next;

    // Compare stage: the stored region against the broadcast key.
    always_comb begin
        flag_next.valid         = valid_reg;
        flag_next.below         = valid_reg && (start_reg < cmd.key);
        flag_next.le            = valid_reg && (start_reg <= cmd.key);
        flag_next.key_lt_end    = cmd.key < end_reg;
        flag_next.key_le_end    = cmd.key <= end_reg;
        flag_next.start_lt_kend = start_reg < cmd.key_end;
    end

    // Update stage: an insert opens a gap at the first cell not below the key,
    // a remove closes the gap from the matching cell upwards.
    always_comb begin
        valid_next = valid_reg;
        start_next = start_reg;
        end_next   = end_reg;
        if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.ins && !flag_reg.below) begin
            if (left_below) begin
                valid_next = 1'b1;
                start_next = cmd.key;
                end_next   = cmd.key_end;
            end else begin
                valid_next = left_entry.valid;
                start_next = left_entry.start_addr;
                end_next   = left_entry.end_addr;
            end
        end else if (ctl.rem && !flag_reg.below) begin
            valid_next = right_entry.valid;
            start_next = right_entry.start_addr;
            end_next   = right_entry.end_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        flag_reg  <= flag_next;
    end

    assign entry.valid      = valid_reg;
    assign entry.start_addr = start_reg;
    assign entry.end_addr   = end_reg;
    assign flag             = flag_reg;

endmodule

`default_nettype wire

[hdl/address_range_table_top.sv]
// A result is registered once its request has passed the compare stage and
// the update stage of the cell chain; a new request can be accepted as the
// previous one completes its update stage, not before.
// A held result stalls the next update until it is taken.
// Reset (aresetn low, synchronous) clears every cell's valid flag, the region
// count and the result valid flag; no clearing sweep is needed.
`default_nettype none

module address_range_table_top #(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] address, [127:64] range_limit
    input  wire logic [1:0]   s_tuser,   // [1:0] operation
    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata    // [2:0] status, [3] hit, [67:4] bound_start,
                                         // [131:68] bound_end, [136:132] region_count
);
    import art_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);

    // The table is a chain of cells kept sorted by start, with every held
    // region packed at the low end of the chain. A request is first
    // broadcast to all cells, which register their compare results; the
    // sequencer then combines those flags and, for an insert or remove,
    // tells the chain to shift by one place around the right cell.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    state_t                  state_reg;
    art_op_t                 op_reg;
    art_cmd_t                cmd_reg;
    logic                    m_valid_reg;
    logic [143:0]            m_data_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    art_entry_t              entry [MAX_REGIONS];
    art_flag_t               flag  [MAX_REGIONS];
    art_ctl_t                ctl;

    logic                    accept;
    logic                    out_free;
    logic                    apply;

    logic [MAX_REGIONS-1:0]  match_vec;
    logic [MAX_REGIONS-1:0]  pred_vec;
    logic [MAX_REGIONS-1:0]  succ_vec;
    logic [MAX_REGIONS-1:0]  hit_vec;
    logic                    found;
    logic                    overlap;
    logic                    full;
    logic                    hit;
    logic [ADDR_W-1:0]       bound_start;
    logic [ADDR_W-1:0]       bound_end;
    art_status_t             status;

    // The cell chain. The first cell sees a virtual neighbour that is always
    // below the key, so an insert in front of everything lands in it; the last
    // cell pulls in an empty entry when the chain closes up after a remove.
    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        logic       left_below;
        art_entry_t left_entry;
        art_entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_below = 1'b1;
            assign left_entry = '0;
        end else begin : g_inner
            assign left_below = flag[i-1].below;
            assign left_entry = entry[i-1];
        end

        if (i == MAX_REGIONS - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_next
            assign right_entry = entry[i+1];
        end

        art_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd_reg),
            .ctl         (ctl),
            .left_below  (left_below),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry[i]),
            .flag        (flag[i])
        );
    end

    // Each cell finds out from its own flags and those of its neighbours
    // whether it is the match, the predecessor, the successor or the lookup
    // candidate; the sorted order makes each of these at most one cell.
    // Only a lookup may report a matching region, so the other requests
    // return zero bounds.
    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            logic below_next;
            logic le_next;
            logic below_prev;
            below_next   = (i == MAX_REGIONS - 1) ? 1'b0 : flag[(i+1) % MAX_REGIONS].below;
            le_next      = (i == MAX_REGIONS - 1) ? 1'b0 : flag[(i+1) % MAX_REGIONS].le;
            below_prev   = (i == 0) ? 1'b1 : flag[(i+MAX_REGIONS-1) % MAX_REGIONS].below;
            match_vec[i] = flag[i].le && !flag[i].below;
            pred_vec[i]  = flag[i].below && !below_next && flag[i].key_lt_end;
            succ_vec[i]  = flag[i].valid && !flag[i].below && below_prev
                           && flag[i].start_lt_kend;
            hit_vec[i]   = (op_reg == OP_LOOKUP) && flag[i].le && !le_next
                           && flag[i].key_le_end;
        end
    end

    always_comb begin
        bound_start = '0;
        bound_end   = '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            bound_start = bound_start | (entry[i].start_addr & {ADDR_W{hit_vec[i]}});
            bound_end   = bound_end   | (entry[i].end_addr   & {ADDR_W{hit_vec[i]}});
        end
    end

    assign found   = |match_vec;
    assign overlap = |pred_vec || |succ_vec;
    assign full    = (count_reg == CW'(MAX_REGIONS));
    assign hit     = (op_reg == OP_LOOKUP) && |hit_vec;

    // Status codes, with the insert checks in their order of priority.
    always_comb begin
        status = STAT_OK;
        case (op_reg)
            OP_INSERT: begin
                if (found) begin
                    status = STAT_DUPLICATE;
                end else if (full) begin
                    status = STAT_FULL;
                end else if (overlap) begin
                    status = STAT_OVERLAP;
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    status = STAT_NOT_FOUND;
                end
            end
            default: begin
                status = STAT_OK;
            end
        endcase
    end

    // The update stage runs only when the result register can take the result.
    assign out_free = !m_valid_reg || m_tready;
    assign apply    = (state_reg == S_APPLY) && out_free;
    assign s_tready = (state_reg == S_IDLE) || apply;
    assign accept   = s_tvalid && s_tready;

    assign ctl.ins = apply && (op_reg == OP_INSERT) && (status == STAT_OK);
    assign ctl.rem = apply && (op_reg == OP_REMOVE) && found;
    assign ctl.clr = apply && (op_reg == OP_CLEAR);

    always_comb begin
        count_next = count_reg;
        if (ctl.clr) begin
            count_next = '0;
        end else if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (m_tready && !apply) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                op_reg          <= art_op_t'(s_tuser);
                cmd_reg.key     <= s_tdata[63:0];
                cmd_reg.key_end <= s_tdata[127:64];
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (apply) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(count_next),
                                        bound_end, bound_start, hit, status};
                        count_reg   <= count_next;
                        state_reg   <= accept ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[hdl/art_checker.sv]
`default_nettype none

module art_checker #(
    parameter int MAX_REGIONS = 16
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata
);
    import art_pkg::*;

    // A held result keeps its value until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the port closes after each acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in the cycle after another");

    // A hit only comes with an ok status, and status stays within its codes.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == STAT_OK || m_tdata[2:0] == STAT_OVERLAP
                      || m_tdata[2:0] == STAT_DUPLICATE || m_tdata[2:0] == STAT_FULL
                      || m_tdata[2:0] == STAT_NOT_FOUND)
                     && (!m_tdata[3] || m_tdata[2:0] == STAT_OK))
        else $error("bad status or hit combination");

    // A miss reports zero bounds.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[131:4] == '0)
        else $error("non-zero bounds on a miss");

    // The count never exceeds the table size; checked only for tables of under 32 regions.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && MAX_REGIONS < 32 |-> 32'(m_tdata[136:132]) <= MAX_REGIONS)
        else $error("region count above table size");

endmodule

bind address_range_table_top art_checker #(
    .MAX_REGIONS (MAX_REGIONS)
) u_art_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
